FILE: rtl/closest_hit_ray_triangle_pick_top_macros.svh
// Assertion macros for the ray/triangle pick RTL.
`ifndef CLOSEST_HIT_RAY_TRIANGLE_PICK_TOP_MACROS_SVH
`define CLOSEST_HIT_RAY_TRIANGLE_PICK_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CHP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define CHP_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

FILE: rtl/chp_pkg.sv
// Types, constants and the multiply-accumulate program of the ray/triangle pick.
package chp_pkg;

  localparam int CW   = 32;   // coordinate width
  localparam int EW   = 33;   // edge / difference width, short multiplier operand
  localparam int BW   = 67;   // long multiplier operand (cross products)
  localparam int WW   = 102;  // dot product results
  localparam int AW   = 104;  // accumulator
  localparam int PW   = 64;   // hit point product
  localparam int TW   = 31;   // distance
  localparam int FW   = 16;   // face number
  localparam int EPSW = 16;
  localparam int RIW  = 3;
  localparam int OPW  = 5;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int MAX_FACES_DEF       = 65536;

  typedef enum logic [RIW-1:0] {
    REG_OX, REG_OY, REG_OZ, REG_DX, REG_DY, REG_DZ, REG_EPS
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] vertex_a_x;
    logic signed [CW-1:0] vertex_a_y;
    logic signed [CW-1:0] vertex_a_z;
    logic signed [CW-1:0] vertex_b_x;
    logic signed [CW-1:0] vertex_b_y;
    logic signed [CW-1:0] vertex_b_z;
    logic signed [CW-1:0] vertex_c_x;
    logic signed [CW-1:0] vertex_c_y;
    logic signed [CW-1:0] vertex_c_z;
    logic                 last_triangle;
  } triangle_t;

  typedef struct packed {
    logic                 has_hit;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
    logic [TW-1:0]        hit_distance;
    logic [FW-1:0]        face_number;
  } result_t;

  typedef enum logic [3:0] {
    A_DX, A_DY, A_DZ, A_E1X, A_E1Y, A_E1Z, A_E2X, A_E2Y, A_E2Z,
    A_SX, A_SY, A_SZ, A_TB
  } a_sel_t;

  typedef enum logic [3:0] {
    B_E1X, B_E1Y, B_E1Z, B_E2X, B_E2Y, B_E2Z, B_HX, B_HY, B_HZ,
    B_QX, B_QY, B_QZ, B_DX, B_DY, B_DZ
  } b_sel_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_HX, DST_HY, DST_HZ, DST_DET, DST_U, DST_QX, DST_QY, DST_QZ,
    DST_V, DST_T, DST_PX, DST_PY, DST_PZ
  } dst_t;

  typedef struct packed {
    a_sel_t a;
    b_sel_t b;
    logic   sub;
    logic   clr;
    dst_t   dst;
  } mac_op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MAC_GO, S_MAC_WAIT, S_CHECK, S_DIV_WAIT, S_UPDATE, S_COUNT, S_EMIT
  } state_t;

  localparam logic [OPW-1:0] OP_GEOM_FIRST = 5'd0;
  localparam logic [OPW-1:0] OP_GEOM_LAST  = 5'd23;
  localparam logic [OPW-1:0] OP_PT_FIRST   = 5'd24;
  localparam logic [OPW-1:0] OP_PT_LAST    = 5'd26;

  typedef struct packed {
    logic    load;
    logic    mac_start;
    logic    write;
    mac_op_t op;
    logic    div_start;
    logic    best_update;
    logic    count;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic mac_done;
    logic div_done;
    logic geom_pass;
    logic better;
    logic best_valid;
    logic last;
    logic out_free;
  } status_t;

  function automatic mac_op_t mac_op(input a_sel_t a, input b_sel_t b,
                                     input logic sub, input logic clr, input dst_t dst);
    mac_op_t o;
    o.a = a; o.b = b; o.sub = sub; o.clr = clr; o.dst = dst;
    return o;
  endfunction

  // h = d x e2, det = e1.h, u = s.h, q = s x e1, v = d.q, t = e2.q, then t*d per axis
  function automatic mac_op_t mac_program(input logic [OPW-1:0] idx);
    mac_op_t o;
    case (idx)
      5'd0:  o = mac_op(A_DY,  B_E2Z, 1'b0, 1'b1, DST_NONE);
      5'd1:  o = mac_op(A_DZ,  B_E2Y, 1'b1, 1'b0, DST_HX);
      5'd2:  o = mac_op(A_DZ,  B_E2X, 1'b0, 1'b1, DST_NONE);
      5'd3:  o = mac_op(A_DX,  B_E2Z, 1'b1, 1'b0, DST_HY);
      5'd4:  o = mac_op(A_DX,  B_E2Y, 1'b0, 1'b1, DST_NONE);
      5'd5:  o = mac_op(A_DY,  B_E2X, 1'b1, 1'b0, DST_HZ);
      5'd6:  o = mac_op(A_E1X, B_HX,  1'b0, 1'b1, DST_NONE);
      5'd7:  o = mac_op(A_E1Y, B_HY,  1'b0, 1'b0, DST_NONE);
      5'd8:  o = mac_op(A_E1Z, B_HZ,  1'b0, 1'b0, DST_DET);
      5'd9:  o = mac_op(A_SX,  B_HX,  1'b0, 1'b1, DST_NONE);
      5'd10: o = mac_op(A_SY,  B_HY,  1'b0, 1'b0, DST_NONE);
      5'd11: o = mac_op(A_SZ,  B_HZ,  1'b0, 1'b0, DST_U);
      5'd12: o = mac_op(A_SY,  B_E1Z, 1'b0, 1'b1, DST_NONE);
      5'd13: o = mac_op(A_SZ,  B_E1Y, 1'b1, 1'b0, DST_QX);
      5'd14: o = mac_op(A_SZ,  B_E1X, 1'b0, 1'b1, DST_NONE);
      5'd15: o = mac_op(A_SX,  B_E1Z, 1'b1, 1'b0, DST_QY);
      5'd16: o = mac_op(A_SX,  B_E1Y, 1'b0, 1'b1, DST_NONE);
      5'd17: o = mac_op(A_SY,  B_E1X, 1'b1, 1'b0, DST_QZ);
      5'd18: o = mac_op(A_DX,  B_QX,  1'b0, 1'b1, DST_NONE);
      5'd19: o = mac_op(A_DY,  B_QY,  1'b0, 1'b0, DST_NONE);
      5'd20: o = mac_op(A_DZ,  B_QZ,  1'b0, 1'b0, DST_V);
      5'd21: o = mac_op(A_E2X, B_QX,  1'b0, 1'b1, DST_NONE);
      5'd22: o = mac_op(A_E2Y, B_QY,  1'b0, 1'b0, DST_NONE);
      5'd23: o = mac_op(A_E2Z, B_QZ,  1'b0, 1'b0, DST_T);
      5'd24: o = mac_op(A_TB,  B_DX,  1'b0, 1'b1, DST_PX);
      5'd25: o = mac_op(A_TB,  B_DY,  1'b0, 1'b1, DST_PY);
      5'd26: o = mac_op(A_TB,  B_DZ,  1'b0, 1'b1, DST_PZ);
      default: o = mac_op(A_DX, B_DX, 1'b0, 1'b1, DST_NONE);
    endcase
    return o;
  endfunction

endpackage

FILE: rtl/chp_stream_if.sv
// Valid/ready stream channel carrying one word of payload.
interface chp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/closest_hit_ray_triangle_pick_top.sv
// Top level of the closest-hit ray/triangle picker.
// Takes one triangle word at a time on the triangle channel and tests it against the
// ray held in the configuration registers (origin, direction, epsilon, indexes 0 to 6,
// written by the user only while the block is idle; the block does not enforce it).
// All products run in turn through one bit-serial multiply-accumulate unit: 24
// products, then a divide for the hit distance when the triangle passes the facing,
// parallel, barycentric and in-front tests. The word marked as last of its batch adds
// three more products for the hit point when the batch has a hit, then loads the
// result register; the next triangle is taken while the result waits.
// Back faces are culled, the nearest hit is kept and an equal distance keeps the
// earlier face. With no hit in the batch the result word is all zero.
module closest_hit_ray_triangle_pick_top import chp_pkg::*; #(
  parameter int MAX_FACES       = MAX_FACES_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  chp_stream_if.sink     triangle,
  chp_stream_if.source   result,
  input  logic           cfg_we,
  input  logic [RIW-1:0] cfg_index,
  input  logic [CW-1:0]  cfg_data
);
  cmd_t      cmd;
  status_t   sts;
  triangle_t tri_data;
  logic      in_ready;

  assign tri_data       = triangle.data;
  assign triangle.ready = in_ready;

  // sequencer: accepts a word only between triangles
  chp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (triangle.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, batch state and the result register
  chp_datapath #(
    .MAX_FACES       (MAX_FACES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tri_data  (tri_data),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );
endmodule

FILE: rtl/chp_mac.sv
// Bit-serial signed multiply-accumulate unit.
module chp_mac import chp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 clr,
  input  logic                 sub,
  input  logic signed [EW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic                 busy,
  output logic                 done,
  output logic signed [AW-1:0] acc
);
  localparam int CNTW = $clog2(EW);

  logic [EW-1:0]        a_sh;
  logic signed [AW-1:0] b_sh;
  logic [CNTW-1:0]      cnt;
  logic                 sub_r;
  logic                 top_bit;
  logic                 neg;

  assign top_bit = (cnt == CNTW'(EW - 1));
  // the sign bit of a carries negative weight
  assign neg = sub_r ^ top_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && top_bit;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && top_bit) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= a;
      b_sh  <= {{(AW-BW){b[BW-1]}}, b};
      cnt   <= '0;
      sub_r <= sub;
      if (clr) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (a_sh[0]) begin
        acc <= neg ? acc - b_sh : acc + b_sh;
      end
      a_sh <= a_sh >> 1;
      b_sh <= b_sh <<< 1;
      cnt  <= cnt + CNTW'(1);
    end
  end
endmodule

FILE: rtl/chp_div.sv
// Restoring divider: saturated floor(t * 2^F / det), one quotient bit per cycle.
module chp_div import chp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [WW-1:0] num,
  input  logic [WW-1:0] den,
  output logic          done,
  output logic [TW-1:0] quo
);
  localparam int DIVW = ((WW + COORD_FRAC_BITS) > (WW + TW) ?
                         (WW + COORD_FRAC_BITS) : (WW + TW)) + 1;
  localparam int CNTW = $clog2(TW + 1);

  logic [DIVW-1:0] r;
  logic [DIVW-1:0] d;
  logic [TW-1:0]   q;
  logic [CNTW-1:0] cnt;
  logic            sat;
  logic            busy;
  logic            ge;
  logic            fin;

  assign ge  = (r >= d);
  assign fin = (cnt == CNTW'(TW));
  assign quo = sat ? {TW{1'b1}} : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && fin;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && fin) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= DIVW'(num) << COORD_FRAC_BITS;
      d   <= DIVW'(den) << TW;
      q   <= '0;
      cnt <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      // first compare against det * 2^31 only detects overflow
      if (cnt == '0) begin
        sat <= ge;
      end else begin
        if (ge) begin
          r <= r - d;
        end
        q <= {q[TW-2:0], ge};
      end
      d   <= d >> 1;
      cnt <= cnt + CNTW'(1);
    end
  end
endmodule

FILE: rtl/chp_ctrl.sv
// Sequencer of the ray/triangle pick: steps the MAC program, divide and emit.
`include "closest_hit_ray_triangle_pick_top_macros.svh"
module chp_ctrl import chp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);
  state_t         state, state_next;
  logic [OPW-1:0] op_idx, op_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op_idx <= OP_GEOM_FIRST;
    end else begin
      state  <= state_next;
      op_idx <= op_idx_next;
    end
  end

  always_comb begin
    state_next  = state;
    op_idx_next = op_idx;
    cmd         = '0;
    cmd.op      = mac_program(op_idx);
    in_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          op_idx_next = OP_GEOM_FIRST;
          state_next  = S_MAC_GO;
        end
      end
      S_MAC_GO: begin
        cmd.mac_start = 1'b1;
        state_next    = S_MAC_WAIT;
      end
      S_MAC_WAIT: begin
        if (sts.mac_done) begin
          cmd.write = 1'b1;
          if (op_idx == OP_GEOM_LAST) begin
            state_next = S_CHECK;
          end else if (op_idx == OP_PT_LAST) begin
            state_next = S_EMIT;
          end else begin
            op_idx_next = op_idx + OPW'(1);
            state_next  = S_MAC_GO;
          end
        end
      end
      S_CHECK: begin
        if (sts.geom_pass) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV_WAIT;
        end else begin
          state_next = S_COUNT;
        end
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.best_update = sts.better;
        state_next      = S_COUNT;
      end
      S_COUNT: begin
        cmd.count = 1'b1;
        if (!sts.last) begin
          state_next = S_IDLE;
        end else if (sts.best_valid) begin
          op_idx_next = OP_PT_FIRST;
          state_next  = S_MAC_GO;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `CHP_ASSERT(a_mac_start_idle, clk, rst, cmd.mac_start |-> !sts.mac_busy, "MAC restarted while busy")
  `CHP_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready, "second word taken while busy")
  `CHP_ASSERT(a_emit_free, clk, rst, cmd.emit |-> sts.out_free, "result register overwritten")
endmodule

FILE: rtl/chp_datapath.sv
// Datapath of the ray/triangle pick: ray registers, operands, MAC, divider, result.
module chp_datapath import chp_pkg::*; #(
  parameter int MAX_FACES       = MAX_FACES_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [RIW-1:0]       cfg_index,
  input  logic [CW-1:0]        cfg_data,
  input  triangle_t            tri_data,
  input  cmd_t                 cmd,
  output status_t              sts,
  chp_stream_if.source         result
);
  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];
  logic [EPSW-1:0]      eps;

  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] sv [3];
  logic                 last;

  logic signed [BW-1:0] h [3];
  logic signed [BW-1:0] q [3];
  logic signed [WW-1:0] det, u, v, t;
  logic signed [PW-1:0] p [3];

  logic                 best_valid;
  logic [TW-1:0]        best_dist;
  logic [FW-1:0]        best_face;
  logic [FW-1:0]        face_cnt;
  logic [FW:0]          face_inc;

  logic                 out_valid;
  result_t              out_data;

  logic signed [EW-1:0] mac_a;
  logic signed [BW-1:0] mac_b;
  logic signed [AW-1:0] acc;
  logic                 mac_busy, mac_done;
  logic                 div_done;
  logic [TW-1:0]        div_q;

  logic [WW-1:0]        eps_det;
  logic signed [WW:0]   u_plus_v;

  function automatic logic signed [BW-1:0] ext_e(input logic signed [EW-1:0] x);
    return {{(BW-EW){x[EW-1]}}, x};
  endfunction

  function automatic logic signed [CW-1:0] hit_axis(input logic signed [CW-1:0] o,
                                                    input logic signed [PW-1:0] prod);
    logic signed [PW-1:0] sh;
    logic signed [PW:0]   sum;
    sh  = prod >>> COORD_FRAC_BITS;
    sum = {{(PW+1-CW){o[CW-1]}}, o} + {sh[PW-1], sh};
    if (!sum[PW] && (|sum[PW-1:CW-1])) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (sum[PW] && !(&sum[PW-1:CW-1])) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return sum[CW-1:0];
  endfunction

  // ray registers
  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= CW'(64'd1 << COORD_FRAC_BITS);
      eps    <= EPSW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OX:  org[0] <= cfg_data;
        REG_OY:  org[1] <= cfg_data;
        REG_OZ:  org[2] <= cfg_data;
        REG_DX:  dir[0] <= cfg_data;
        REG_DY:  dir[1] <= cfg_data;
        REG_DZ:  dir[2] <= cfg_data;
        REG_EPS: eps    <= cfg_data[EPSW-1:0];
        default: ;
      endcase
    end
  end

  // edges and origin offset, exact in 33 bits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e1[0] <= EW'(tri_data.vertex_b_x) - EW'(tri_data.vertex_a_x);
      e1[1] <= EW'(tri_data.vertex_b_y) - EW'(tri_data.vertex_a_y);
      e1[2] <= EW'(tri_data.vertex_b_z) - EW'(tri_data.vertex_a_z);
      e2[0] <= EW'(tri_data.vertex_c_x) - EW'(tri_data.vertex_a_x);
      e2[1] <= EW'(tri_data.vertex_c_y) - EW'(tri_data.vertex_a_y);
      e2[2] <= EW'(tri_data.vertex_c_z) - EW'(tri_data.vertex_a_z);
      sv[0] <= EW'(org[0]) - EW'(tri_data.vertex_a_x);
      sv[1] <= EW'(org[1]) - EW'(tri_data.vertex_a_y);
      sv[2] <= EW'(org[2]) - EW'(tri_data.vertex_a_z);
      last  <= tri_data.last_triangle;
    end
  end

  always_comb begin
    case (cmd.op.a)
      A_DX:    mac_a = EW'(dir[0]);
      A_DY:    mac_a = EW'(dir[1]);
      A_DZ:    mac_a = EW'(dir[2]);
      A_E1X:   mac_a = e1[0];
      A_E1Y:   mac_a = e1[1];
      A_E1Z:   mac_a = e1[2];
      A_E2X:   mac_a = e2[0];
      A_E2Y:   mac_a = e2[1];
      A_E2Z:   mac_a = e2[2];
      A_SX:    mac_a = sv[0];
      A_SY:    mac_a = sv[1];
      A_SZ:    mac_a = sv[2];
      A_TB:    mac_a = {{(EW-TW){1'b0}}, best_dist};
      default: mac_a = '0;
    endcase
  end

  always_comb begin
    case (cmd.op.b)
      B_E1X:   mac_b = ext_e(e1[0]);
      B_E1Y:   mac_b = ext_e(e1[1]);
      B_E1Z:   mac_b = ext_e(e1[2]);
      B_E2X:   mac_b = ext_e(e2[0]);
      B_E2Y:   mac_b = ext_e(e2[1]);
      B_E2Z:   mac_b = ext_e(e2[2]);
      B_HX:    mac_b = h[0];
      B_HY:    mac_b = h[1];
      B_HZ:    mac_b = h[2];
      B_QX:    mac_b = q[0];
      B_QY:    mac_b = q[1];
      B_QZ:    mac_b = q[2];
      B_DX:    mac_b = {{(BW-CW){dir[0][CW-1]}}, dir[0]};
      B_DY:    mac_b = {{(BW-CW){dir[1][CW-1]}}, dir[1]};
      B_DZ:    mac_b = {{(BW-CW){dir[2][CW-1]}}, dir[2]};
      default: mac_b = '0;
    endcase
  end

  chp_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mac_start),
    .clr   (cmd.op.clr),
    .sub   (cmd.op.sub),
    .a     (mac_a),
    .b     (mac_b),
    .busy  (mac_busy),
    .done  (mac_done),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      case (cmd.op.dst)
        DST_HX:  h[0] <= acc[BW-1:0];
        DST_HY:  h[1] <= acc[BW-1:0];
        DST_HZ:  h[2] <= acc[BW-1:0];
        DST_DET: det  <= acc[WW-1:0];
        DST_U:   u    <= acc[WW-1:0];
        DST_QX:  q[0] <= acc[BW-1:0];
        DST_QY:  q[1] <= acc[BW-1:0];
        DST_QZ:  q[2] <= acc[BW-1:0];
        DST_V:   v    <= acc[WW-1:0];
        DST_T:   t    <= acc[WW-1:0];
        DST_PX:  p[0] <= acc[PW-1:0];
        DST_PY:  p[1] <= acc[PW-1:0];
        DST_PZ:  p[2] <= acc[PW-1:0];
        default: ;
      endcase
    end
  end

  // front facing, not parallel, inside the triangle, in front of the origin
  assign eps_det  = WW'(eps) << (2 * COORD_FRAC_BITS);
  assign u_plus_v = {u[WW-1], u} + {v[WW-1], v};
  assign sts.geom_pass = !det[WW-1] && (det != '0) && ($unsigned(det) >= eps_det) &&
                         !u[WW-1] && (u <= det) && !v[WW-1] &&
                         (u_plus_v <= {det[WW-1], det}) &&
                         !t[WW-1] && (t != '0);

  chp_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (t),
    .den   (det),
    .done  (div_done),
    .quo   (div_q)
  );

  assign face_inc = {1'b0, face_cnt} + (FW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      face_cnt   <= '0;
    end else begin
      if (cmd.best_update) begin
        best_valid <= 1'b1;
      end
      if (cmd.emit) begin
        best_valid <= 1'b0;
        face_cnt   <= '0;
      end else if (cmd.count) begin
        if (face_inc[FW] || (32'(face_inc) >= 32'(MAX_FACES))) begin
          face_cnt <= '0;
        end else begin
          face_cnt <= face_inc[FW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.best_update) begin
      best_dist <= div_q;
      best_face <= face_cnt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (best_valid) begin
        out_data.has_hit      <= 1'b1;
        out_data.hit_x        <= hit_axis(org[0], p[0]);
        out_data.hit_y        <= hit_axis(org[1], p[1]);
        out_data.hit_z        <= hit_axis(org[2], p[2]);
        out_data.hit_distance <= best_dist;
        out_data.face_number  <= best_face;
      end else begin
        out_data <= '0;
      end
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  assign sts.mac_busy   = mac_busy;
  assign sts.mac_done   = mac_done;
  assign sts.div_done   = div_done;
  assign sts.better     = (div_q > TW'(eps)) && (!best_valid || (div_q < best_dist));
  assign sts.best_valid = best_valid;
  assign sts.last       = last;
  assign sts.out_free   = !out_valid || result.ready;
endmodule

FILE: verif/chp_checker.sv
// Scoreboard for the closest-hit picker: watches config, triangle and result channels.
module chp_checker import chp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  chp_stream_if          tri_ch,
  chp_stream_if          res_ch,
  input  logic           cfg_we,
  input  logic [RIW-1:0] cfg_index,
  input  logic [CW-1:0]  cfg_data,
  output int             pending,
  output int             failures,
  output int             results,
  output int             hits
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [CW-1:0] org[3];
  logic signed [CW-1:0] dir[3];
  logic [EPSW-1:0]      eps;
  logic                 near_valid;
  logic [TW-1:0]        near_dist;
  logic [FW-1:0]        near_face;
  logic [FW-1:0]        face_idx;
  result_t              pick_q[$];

  // Exact Moller-Trumbore with culling; returns 1 and the distance on a hit
  function automatic bit ray_hits(triangle_t w, output logic [TW-1:0] hit_dist);
    logic signed [127:0] va[3], e1[3], e2[3], s[3], d[3], h[3], q[3];
    logic signed [127:0] det, u, v, t;
    logic [127:0] quo;
    va[0] = w.vertex_a_x; va[1] = w.vertex_a_y; va[2] = w.vertex_a_z;
    e1[0] = w.vertex_b_x; e1[1] = w.vertex_b_y; e1[2] = w.vertex_b_z;
    e2[0] = w.vertex_c_x; e2[1] = w.vertex_c_y; e2[2] = w.vertex_c_z;
    hit_dist = '0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = e1[i] - va[i];
      e2[i] = e2[i] - va[i];
      s[i]  = 128'(signed'(org[i])) - va[i];
      d[i]  = dir[i];
    end
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    if (det <= 0) return 0;                       // back face or degenerate
    if (det < (128'(eps) << 32)) return 0;        // near parallel
    u = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    if (u < 0 || u > det) return 0;
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    v = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    if (v < 0 || u + v > det) return 0;
    t = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (t <= 0) return 0;
    quo = ($unsigned(t) << 16) / $unsigned(det);
    hit_dist = (quo > 128'h7FFF_FFFF) ? 31'h7FFF_FFFF : quo[TW-1:0];
    return 32'(hit_dist) > 32'(eps);
  endfunction

  function automatic logic signed [CW-1:0] point_axis(logic signed [CW-1:0] o,
                                                      logic signed [CW-1:0] dv,
                                                      logic [TW-1:0] t);
    logic signed [63:0] tw, dw, p, sum;
    tw = {33'd0, t};
    dw = dv;
    p = tw * dw;
    sum = 64'(o) + (p >>> 16);
    if (sum > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (sum < -64'sh8000_0000) return 32'sh8000_0000;
    return sum[CW-1:0];
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    logic [TW-1:0] t;
    if (rst) begin
      org = '{0, 0, 0};
      dir = '{0, 0, 32'sh0001_0000};
      eps = 16'd1;
      near_valid = 0; near_dist = '0; near_face = '0; face_idx = '0;
      pick_q.delete();
      failures = 0; results = 0; hits = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_OX:  org[0] = cfg_data;
          REG_OY:  org[1] = cfg_data;
          REG_OZ:  org[2] = cfg_data;
          REG_DX:  dir[0] = cfg_data;
          REG_DY:  dir[1] = cfg_data;
          REG_DZ:  dir[2] = cfg_data;
          REG_EPS: eps = cfg_data[EPSW-1:0];
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        results++;
        if (pick_q.size() == 0) begin
          $error("result word with nothing expected");
          failures++;
        end else begin
          want = pick_q.pop_front();
          if (got.has_hit !== want.has_hit) begin
            $error("has_hit exp %0d got %0d", want.has_hit, got.has_hit); failures++;
          end
          if (got.hit_x !== want.hit_x) begin
            $error("hit_x exp %0d got %0d", want.hit_x, got.hit_x); failures++;
          end
          if (got.hit_y !== want.hit_y) begin
            $error("hit_y exp %0d got %0d", want.hit_y, got.hit_y); failures++;
          end
          if (got.hit_z !== want.hit_z) begin
            $error("hit_z exp %0d got %0d", want.hit_z, got.hit_z); failures++;
          end
          if (got.hit_distance !== want.hit_distance) begin
            $error("hit_distance exp %0d got %0d", want.hit_distance, got.hit_distance);
            failures++;
          end
          if (got.face_number !== want.face_number) begin
            $error("face_number exp %0d got %0d", want.face_number, got.face_number);
            failures++;
          end
        end
      end
      if (tri_ch.valid && tri_ch.ready) begin
        triangle_t w;
        w = tri_ch.data;
        if (ray_hits(w, t) && (!near_valid || t < near_dist)) begin
          near_valid = 1; near_dist = t; near_face = face_idx;
        end
        face_idx = face_idx + 1'b1;   // 16-bit wrap matches the face limit
        if (w.last_triangle) begin
          want = '0;
          if (near_valid) begin
            want.has_hit = 1;
            want.hit_x = point_axis(org[0], dir[0], near_dist);
            want.hit_y = point_axis(org[1], dir[1], near_dist);
            want.hit_z = point_axis(org[2], dir[2], near_dist);
            want.hit_distance = near_dist;
            want.face_number = near_face;
            hits++;
          end
          pick_q = {pick_q, want};
          near_valid = 0; near_dist = '0; near_face = '0; face_idx = '0;
        end
      end
    end
    pending = pick_q.size();
  end

  final if (pick_q.size() != 0) $error("%0d result words never arrived", pick_q.size());

endmodule

FILE: verif/tb.sv
// Testbench top for the closest-hit picker: stimulus, config phases and verdict.
module tb import chp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [RIW-1:0] REG_UNUSED = 3'd7;   // index past the register map
  localparam int ONE        = 65536;              // 1.0 in Q16.16
  localparam int STALL_LIMIT = 20000;             // a triangle's work plus gaps, many times over
  localparam int DRAIN      = 1200;               // one triangle plus the point pass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [RIW-1:0] cfg_index = '0;
  logic [CW-1:0]  cfg_data = '0;

  chp_stream_if #(.T(triangle_t)) tri_ch();
  chp_stream_if #(.T(result_t))   res_ch();

  int pending, failures, results, hits;
  int words_sent = 0;
  int idle_cycles = 0;
  bit calm = 0;        // when set, neither side inserts gaps
  int res_stall = 0;

  // tb copy of the ray, used only to aim triangles
  logic signed [CW-1:0] ray_o[3];
  logic signed [CW-1:0] ray_d[3];

  closest_hit_ray_triangle_pick_top u_dut (
    .clk(clk), .rst(rst), .triangle(tri_ch), .result(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  chp_checker u_chk (
    .clk(clk), .rst(rst), .tri_ch(tri_ch), .res_ch(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .failures(failures), .results(results), .hits(hits)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    tri_ch.valid = 0;
    tri_ch.data = '0;
    res_ch.ready = 0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(30, 300);
  endfunction

  // result side: random back-pressure
  always @(negedge clk) begin
    if (res_stall > 0) begin
      res_stall--;
      res_ch.ready <= 0;
    end else begin
      res_ch.ready <= 1;
      res_stall = pick_gap();
    end
  end

  // watchdog: too long with no word moving on either channel
  always @(posedge clk) begin
    if ((tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[closest_hit_ray_triangle_pick_top] ERROR");
      $finish;
    end
  end

  task automatic send_word(triangle_t w);
    int g;
    g = pick_gap();
    @(negedge clk);
    if (g > 0) begin
      tri_ch.valid <= 0;
      repeat (g) @(negedge clk);
    end
    tri_ch.valid <= 1;
    tri_ch.data <= w;
    @(posedge clk);
    while (!tri_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    tri_ch.valid <= 0;
  endtask

  // waits until the block is idle: nothing pending and the pipe drained
  task automatic settle();
    drop_valid();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [RIW-1:0] idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic set_ray(logic signed [CW-1:0] ox, oy, oz, dx, dy, dz,
                         logic [EPSW-1:0] e);
    write_reg(REG_OX, ox);
    write_reg(REG_OY, oy);
    write_reg(REG_OZ, oz);
    write_reg(REG_DX, dx);
    write_reg(REG_DY, dy);
    write_reg(REG_DZ, dz);
    write_reg(REG_EPS, {16'($urandom_range(0, 65535)), e});   // upper bits must be dropped
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, $urandom());
    @(negedge clk);
    cfg_we <= 0;
    ray_o = '{ox, oy, oz};
    ray_d = '{dx, dy, dz};
  endtask

  // axis-aligned triangle in plane z around the z axis; swap flips the winding
  function automatic triangle_t flat_tri(int z, int hs, bit swap, bit last);
    triangle_t w;
    w.vertex_a_x = -hs;   w.vertex_a_y = -hs;   w.vertex_a_z = z;
    w.vertex_b_x = -hs;   w.vertex_b_y = 3 * hs; w.vertex_b_z = z;
    w.vertex_c_x = 3 * hs; w.vertex_c_y = -hs;  w.vertex_c_z = z;
    if (swap) begin
      w.vertex_b_x = 3 * hs; w.vertex_b_y = -hs;
      w.vertex_c_x = -hs;   w.vertex_c_y = 3 * hs;
    end
    w.last_triangle = last;
    return w;
  endfunction

  // triangle built around a point on the ray; half of them face away
  function automatic triangle_t aimed_tri(bit last);
    triangle_t w;
    longint p[3], e1[3], e2[3], a[3], b[3], c[3];
    longint t0, sp, al, be;
    t0 = $urandom_range(ONE / 8, 64 * ONE);
    sp = longint'($urandom_range(1, 16)) * ONE;
    al = $urandom_range(0, 255);
    be = $urandom_range(0, 255 - al);
    for (int i = 0; i < 3; i++) begin
      p[i]  = longint'(ray_o[i]) + ((t0 * longint'(ray_d[i])) >>> 16);
      e1[i] = longint'($urandom_range(0, 2 * sp)) - sp;
      e2[i] = longint'($urandom_range(0, 2 * sp)) - sp;
      a[i]  = p[i] - (al * e1[i] + be * e2[i]) / 256;
      b[i]  = a[i] + e1[i];
      c[i]  = a[i] + e2[i];
    end
    if ($urandom_range(0, 3) == 0) a[$urandom_range(0, 2)] += $urandom_range(0, 4 * ONE);
    if ($urandom_range(0, 1)) begin
      e1 = b; b = c; c = e1;
    end
    w.vertex_a_x = a[0][31:0]; w.vertex_a_y = a[1][31:0]; w.vertex_a_z = a[2][31:0];
    w.vertex_b_x = b[0][31:0]; w.vertex_b_y = b[1][31:0]; w.vertex_b_z = b[2][31:0];
    w.vertex_c_x = c[0][31:0]; w.vertex_c_y = c[1][31:0]; w.vertex_c_z = c[2][31:0];
    w.last_triangle = last;
    return w;
  endfunction

  function automatic triangle_t noise_tri(bit last);
    triangle_t w;
    w = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom(), $urandom(), $urandom(), 1'b0};
    w.last_triangle = last;
    return w;
  endfunction

  // random batches, mostly aimed geometry with some noise mixed in
  task automatic run_batches(int n_words);
    int left, len;
    bit lst;
    left = n_words;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        lst = (k == len - 1);
        if ($urandom_range(0, 9) == 0) send_word(noise_tri(lst));
        else send_word(aimed_tri(lst));
      end
      left -= len;
    end
  endtask

  function automatic logic signed [CW-1:0] small_coord(int units);
    return $signed($urandom_range(0, 2 * units * ONE)) - units * ONE;
  endfunction

  initial begin
    triangle_t w;
    ray_o = '{0, 0, 0};
    ray_d = '{0, 0, ONE};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // --- directed, reset ray: origin 0, direction +z, epsilon 1 LSB ---
    calm = 1;
    send_word(flat_tri(4 * ONE, ONE, 0, 1));           // plain front hit
    send_word(flat_tri(4 * ONE, ONE, 1, 1));           // back face culled
    send_word(flat_tri(-4 * ONE, ONE, 0, 1));          // behind origin
    send_word(flat_tri(1, ONE, 0, 1));                 // distance not above epsilon
    send_word(flat_tri(2, ONE, 0, 1));                 // just past epsilon
    send_word(flat_tri(6 * ONE, ONE, 0, 0));           // tie: earlier face kept
    send_word(flat_tri(6 * ONE, ONE, 0, 0));
    send_word(flat_tri(9 * ONE, ONE, 0, 0));
    send_word(flat_tri(3 * ONE, ONE, 0, 1));           // later nearer face wins
    w = flat_tri(2 * ONE, ONE, 0, 0);
    w.vertex_a_x = 0; w.vertex_b_x = 0; w.vertex_c_x = 0;
    w.vertex_b_z = 5 * ONE;
    send_word(w);                                      // plane holds the ray: parallel
    w = flat_tri(2 * ONE, ONE, 0, 0);
    w.vertex_a_x = 0; w.vertex_a_y = 0;
    send_word(w);                                      // ray through a vertex
    w = flat_tri(2 * ONE, ONE, 0, 1);
    w.vertex_a_x += 5 * ONE; w.vertex_b_x += 5 * ONE; w.vertex_c_x += 5 * ONE;
    send_word(w);                                      // misses; last word of its batch
    w = '{default: 32'sh7FFF_FFFF, last_triangle: 1'b1};
    send_word(w);
    w = '{default: 32'sh8000_0000, last_triangle: 1'b1};
    send_word(w);
    w = {32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
         32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
         32'sh7FFF_FFFF, 1'b1};
    send_word(w);
    settle();                                          // sender holds off until all arrived

    // slow ray: distances saturate
    set_ray(0, 0, 0, 0, 0, 1, 16'd1);
    send_word(flat_tri(ONE, ONE, 0, 1));
    send_word(flat_tri(100 * ONE, 4 * ONE, 0, 0));
    send_word(flat_tri(200 * ONE, 4 * ONE, 0, 1));     // saturated tie
    settle();
    calm = 0;

    // --- random phases over several ray settings, extremes included ---
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_ray(0, 0, 0, 0, 0, ONE, 16'd1);
        1: set_ray(small_coord(64), small_coord(64), small_coord(64),
                   small_coord(2), small_coord(2), small_coord(2), 16'd0);
        2: set_ray(small_coord(64), small_coord(64), small_coord(64),
                   small_coord(2), small_coord(2), small_coord(2), 16'hFFFF);
        3: set_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF);
        4: set_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                   32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'd0);
        5: set_ray(32'sh7FF0_0000, small_coord(8), 32'sh8010_0000,
                   4 * ONE, small_coord(1), -4 * ONE, 16'd1);
        default: set_ray(small_coord(200), small_coord(200), small_coord(200),
                         small_coord(3), small_coord(3), small_coord(3),
                         16'($urandom_range(0, 300)));
      endcase
      calm = (ph == 7);
      run_batches((ph == 3 || ph == 4) ? 60 : 160);
      settle();
    end
    calm = 0;

    $display("sent %0d triangle words over 12 ray settings; %0d results checked, %0d hits",
             words_sent, results, hits);
    $display("covered culling, parallel, tie, epsilon, saturation and no-hit batches");
    if (failures == 0 && pending == 0) begin
      $display("[closest_hit_ray_triangle_pick_top] OK");
    end else begin
      $display("[closest_hit_ray_triangle_pick_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: closest_hit_ray_triangle_pick_top.f
+incdir+rtl
rtl/chp_pkg.sv
rtl/chp_stream_if.sv
rtl/chp_mac.sv
rtl/chp_div.sv
rtl/chp_ctrl.sv
rtl/chp_datapath.sv
rtl/closest_hit_ray_triangle_pick_top.sv
verif/chp_checker.sv
verif/tb.sv
